>>> src/klc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the keyed line cache.
// Used by the controller, the datapath and the top level; no dependencies.
package klc_pkg;

    // Field widths fixed by the interface.
    localparam int KEY_W   = 64;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 4;
    localparam int SLOT_W  = 4;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;

    // Default table size.
    localparam int ENTRIES_DEFAULT = 16;

    // Saturation point of the use and owner counts.
    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'hF;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_LOOKUP    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ADD_OWNER = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REM_OWNER = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // latch a new request and restart the scan
        logic step;    // scan one entry
        logic commit;  // apply the update and issue the result beat
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;     // the scan found its entry this cycle
        logic miss;    // the scan passed the last entry without a find
    } stat_t;

endpackage

>>> src/klc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module klc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/klc_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine for the keyed line cache.
// Depends on klc_pkg for the command and status structs.
module klc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  klc_pkg::stat_t stat,
    output klc_pkg::cmd_t cmd,
    output logic          busy
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.hit || stat.miss)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands to the datapath.
    assign busy       = (state_reg != S_IDLE);
    assign cmd.load   = start && (state_reg == S_IDLE);
    assign cmd.step   = (state_reg == S_SCAN);
    assign cmd.commit = (state_reg == S_COMMIT);

endmodule

>>> src/klc_datapath.sv
`timescale 1ns / 1ps
// Datapath of the keyed line cache: request latch, entry scan, count arrays and result.
// Depends on klc_pkg and klc_ram.
module klc_datapath #(
    parameter int ENTRIES = klc_pkg::ENTRIES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  klc_pkg::cmd_t                 cmd,
    output klc_pkg::stat_t                stat,
    input  logic [klc_pkg::KIND_W-1:0]    kind,
    input  logic [klc_pkg::KEY_W-1:0]     key,
    input  logic [klc_pkg::WORD_W-1:0]    line_offset,
    input  logic [klc_pkg::WORD_W-1:0]    line_length,
    output logic                          done,
    output logic [klc_pkg::STAT_W-1:0]    status,
    output logic [klc_pkg::SLOT_W-1:0]    slot,
    output logic [klc_pkg::WORD_W-1:0]    found_offset,
    output logic [klc_pkg::WORD_W-1:0]    found_length
);

    localparam int IW     = $clog2(ENTRIES);
    localparam int LINE_W = klc_pkg::KEY_W + 2 * klc_pkg::WORD_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    // Latched request.
    logic [klc_pkg::KIND_W-1:0] req_kind_reg;
    logic [klc_pkg::KEY_W-1:0]  req_key_reg;
    logic [klc_pkg::WORD_W-1:0] req_off_reg;
    logic [klc_pkg::WORD_W-1:0] req_len_reg;

    // Scan pointers: issue stage, and a compare stage registered from it.
    logic [IW-1:0] scan_idx_reg;
    logic          issue_live_reg;
    logic [IW-1:0] cmp_idx_reg;
    logic          cmp_live_reg;

    // Outcome of the scan.
    logic                       found_reg;
    logic [IW-1:0]              found_idx_reg;
    logic [klc_pkg::WORD_W-1:0] hit_off_reg;
    logic [klc_pkg::WORD_W-1:0] hit_len_reg;

    // Per-entry flags and counts.
    logic                        valid_reg [ENTRIES];
    logic [klc_pkg::COUNT_W-1:0] use_reg   [ENTRIES];
    logic [klc_pkg::COUNT_W-1:0] owner_reg [ENTRIES];

    // Result beat.
    logic                       done_reg;
    logic [klc_pkg::STAT_W-1:0] status_reg;
    logic [klc_pkg::SLOT_W-1:0] slot_reg;
    logic [klc_pkg::WORD_W-1:0] foff_reg;
    logic [klc_pkg::WORD_W-1:0] flen_reg;

    logic                       wr_en;
    logic [LINE_W-1:0]          rd_line;
    logic [klc_pkg::KEY_W-1:0]  rd_key;
    logic [klc_pkg::WORD_W-1:0] rd_off;
    logic [klc_pkg::WORD_W-1:0] rd_len;
    logic                       is_insert;
    logic                       free_now;
    logic                       match_now;
    logic [IW-1:0]              hit_idx;

    // Line store: key, offset and length of each entry.
    assign wr_en = cmd.commit && found_reg && is_insert;

    klc_ram #(
        .WIDTH (LINE_W),
        .DEPTH (ENTRIES)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (found_idx_reg),
        .wr_data ({req_key_reg, req_off_reg, req_len_reg}),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_line)
    );

    assign rd_key = rd_line[LINE_W-1 -: klc_pkg::KEY_W];
    assign rd_off = rd_line[2*klc_pkg::WORD_W-1 -: klc_pkg::WORD_W];
    assign rd_len = rd_line[klc_pkg::WORD_W-1:0];

    // Per-cycle match tests: a free entry for insert, a valid key match otherwise.
    assign is_insert = (req_kind_reg == klc_pkg::KIND_INSERT);
    assign free_now  = issue_live_reg && (owner_reg[scan_idx_reg] == '0);
    assign match_now = cmp_live_reg && valid_reg[cmp_idx_reg] && (rd_key == req_key_reg);

    assign stat.hit  = is_insert ? free_now : match_now;
    assign stat.miss = is_insert
                     ? (issue_live_reg && (scan_idx_reg == LAST_IDX) && !free_now)
                     : (cmp_live_reg && (cmp_idx_reg == LAST_IDX) && !match_now);
    assign hit_idx   = is_insert ? scan_idx_reg : cmp_idx_reg;

    // Request latch.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_kind_reg <= kind;
            req_key_reg  <= key;
            req_off_reg  <= line_offset;
            req_len_reg  <= line_length;
        end
    end

    // Scan pointers and find capture.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg   <= '0;
            issue_live_reg <= 1'b0;
            cmp_idx_reg    <= '0;
            cmp_live_reg   <= 1'b0;
            found_reg      <= 1'b0;
            found_idx_reg  <= '0;
        end
        else if (cmd.load)
        begin
            scan_idx_reg   <= '0;
            issue_live_reg <= 1'b1;
            cmp_live_reg   <= 1'b0;
            found_reg      <= 1'b0;
        end
        else if (cmd.step)
        begin
            cmp_idx_reg  <= scan_idx_reg;
            cmp_live_reg <= issue_live_reg;
            if (scan_idx_reg == LAST_IDX)
            begin
                issue_live_reg <= 1'b0;
            end
            else
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (stat.hit)
            begin
                found_reg     <= 1'b1;
                found_idx_reg <= hit_idx;
            end
        end
    end

    // Stored offset and length of a key match.
    always_ff @(posedge clk)
    begin
        if (cmd.step && stat.hit)
        begin
            hit_off_reg <= rd_off;
            hit_len_reg <= rd_len;
        end
    end

    // Valid bits and counts, updated in the commit cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
                use_reg[i]   <= '0;
                owner_reg[i] <= '0;
            end
        end
        else if (cmd.commit && found_reg)
        begin
            case (req_kind_reg)
                klc_pkg::KIND_INSERT:
                begin
                    valid_reg[found_idx_reg] <= 1'b1;
                    use_reg[found_idx_reg]   <= klc_pkg::COUNT_W'(1);
                    owner_reg[found_idx_reg] <= '0;
                end
                klc_pkg::KIND_LOOKUP:
                begin
                    if (use_reg[found_idx_reg] != klc_pkg::COUNT_MAX)
                    begin
                        use_reg[found_idx_reg] <= use_reg[found_idx_reg] + 1'b1;
                    end
                end
                klc_pkg::KIND_ADD_OWNER:
                begin
                    if (owner_reg[found_idx_reg] != klc_pkg::COUNT_MAX)
                    begin
                        owner_reg[found_idx_reg] <= owner_reg[found_idx_reg] + 1'b1;
                    end
                end
                default:
                begin
                    if (owner_reg[found_idx_reg] != '0)
                    begin
                        owner_reg[found_idx_reg] <= owner_reg[found_idx_reg] - 1'b1;
                    end
                end
            endcase
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (!found_reg)
            begin
                status_reg <= is_insert ? klc_pkg::STATUS_FULL : klc_pkg::STATUS_NOT_FOUND;
                slot_reg   <= '0;
                foff_reg   <= '0;
                flen_reg   <= '0;
            end
            else
            begin
                status_reg <= klc_pkg::STATUS_OK;
                slot_reg   <= klc_pkg::SLOT_W'(found_idx_reg);
                if (req_kind_reg == klc_pkg::KIND_LOOKUP)
                begin
                    foff_reg <= hit_off_reg;
                    flen_reg <= hit_len_reg;
                end
                else
                begin
                    foff_reg <= '0;
                    flen_reg <= '0;
                end
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign slot         = slot_reg;
    assign found_offset = foff_reg;
    assign found_length = flen_reg;

endmodule

>>> src/keyed_line_cache_with_owner_counts.sv
`timescale 1ns / 1ps
// Keyed line cache top level: one request at a time, scanned one entry per cycle.
// A key match is found in the compare stage, which reads the registered line RAM output; an insert
// takes the first entry with no owners, found in the issue stage; a key miss or a full table is seen
// at the last entry. The line RAM read port sets the one-entry-per-cycle scan.
// busy covers the whole scan; the next request may start in the cycle of the result beat.
// The receiver cannot stall; done marks a one-cycle result beat.
// Reset clears all valid bits and counts at once; no clearing pass is needed.
module keyed_line_cache_with_owner_counts #(
    parameter int ENTRIES = klc_pkg::ENTRIES_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [klc_pkg::KIND_W-1:0] kind,
    input  logic [klc_pkg::KEY_W-1:0]  key,
    input  logic [klc_pkg::WORD_W-1:0] line_offset,
    input  logic [klc_pkg::WORD_W-1:0] line_length,
    output logic                       done,
    output logic [klc_pkg::STAT_W-1:0] status,
    output logic [klc_pkg::SLOT_W-1:0] slot,
    output logic [klc_pkg::WORD_W-1:0] found_offset,
    output logic [klc_pkg::WORD_W-1:0] found_length
);

    klc_pkg::cmd_t  cmd;
    klc_pkg::stat_t stat;

    // Controller.
    klc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Datapath.
    klc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .kind         (kind),
        .key          (key),
        .line_offset  (line_offset),
        .line_length  (line_length),
        .done         (done),
        .status       (status),
        .slot         (slot),
        .found_offset (found_offset),
        .found_length (found_length)
    );

    // A result beat only comes after the controller has gone idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // An accepted request keeps the block busy in the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // A find and a miss are never reported together.
    a_hit_miss: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !(stat.hit && stat.miss))
        else $error("scan reports hit and miss at once");

    // A failed request returns zero slot and zero data.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != klc_pkg::STATUS_OK)
            |-> (slot == '0 && found_offset == '0 && found_length == '0))
        else $error("failed request with nonzero payload");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the keyed line cache with owner counts.
// Depends on klc_pkg and keyed_line_cache_with_owner_counts; runs a directed part, then random
// request sequences checked against a cycle-free table model kept in this file.
module tb;

    localparam int N_ENTRIES   = klc_pkg::ENTRIES_DEFAULT;
    localparam int ITEM_TARGET = 650;
    localparam int POOL_SIZE   = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 25;

    // One request beat as the driver presents it.
    typedef struct {
        logic [klc_pkg::KIND_W-1:0] kind;
        logic [klc_pkg::KEY_W-1:0]  key;
        logic [klc_pkg::WORD_W-1:0] offset;
        logic [klc_pkg::WORD_W-1:0] length;
        bit                         drain;   // hold off until every result is back
    } request_t;

    // One result beat as the block should answer it.
    typedef struct {
        logic [klc_pkg::STAT_W-1:0] status;
        logic [klc_pkg::SLOT_W-1:0] slot;
        logic [klc_pkg::WORD_W-1:0] offset;
        logic [klc_pkg::WORD_W-1:0] length;
    } answer_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [klc_pkg::KIND_W-1:0] kind;
    logic [klc_pkg::KEY_W-1:0]  key;
    logic [klc_pkg::WORD_W-1:0] line_offset;
    logic [klc_pkg::WORD_W-1:0] line_length;
    logic                       done;
    logic [klc_pkg::STAT_W-1:0] status;
    logic [klc_pkg::SLOT_W-1:0] slot;
    logic [klc_pkg::WORD_W-1:0] found_offset;
    logic [klc_pkg::WORD_W-1:0] found_length;

    // Table model: valid bits, keys, line data and both counts.
    logic                        line_valid [N_ENTRIES];
    logic [klc_pkg::KEY_W-1:0]   line_key   [N_ENTRIES];
    logic [klc_pkg::WORD_W-1:0]  line_off   [N_ENTRIES];
    logic [klc_pkg::WORD_W-1:0]  line_len   [N_ENTRIES];
    logic [klc_pkg::COUNT_W-1:0] use_cnt    [N_ENTRIES];
    logic [klc_pkg::COUNT_W-1:0] own_cnt    [N_ENTRIES];

    request_t   pending [$];
    answer_t    awaiting [$];
    request_t   next_req;
    answer_t    got_beat;
    logic [klc_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

    bit took_beat;
    int n_items;
    int n_sent;
    int n_accepted;
    int n_beats;
    int n_errors;
    int n_hits;
    int n_not_found;
    int n_full;
    int n_clamps;
    int cycles;

    keyed_line_cache_with_owner_counts i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .key          (key),
        .line_offset  (line_offset),
        .line_length  (line_length),
        .done         (done),
        .status       (status),
        .slot         (slot),
        .found_offset (found_offset),
        .found_length (found_length)
    );

    // Clock and a single reset at the start of the run.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Works out the answer to one accepted request and updates the table model.
    function automatic answer_t serve_request(input logic [klc_pkg::KIND_W-1:0] req_kind,
                                              input logic [klc_pkg::KEY_W-1:0]  req_key,
                                              input logic [klc_pkg::WORD_W-1:0] req_off,
                                              input logic [klc_pkg::WORD_W-1:0] req_len);
        answer_t a;
        int      idx;
        int      i;
        a.status = klc_pkg::STATUS_OK;
        a.slot   = '0;
        a.offset = '0;
        a.length = '0;
        idx      = -1;
        if (req_kind == klc_pkg::KIND_INSERT)
        begin
            // First entry with no owners, empty or not.
            for (i = N_ENTRIES - 1; i >= 0; i--)
                if (own_cnt[i] == '0)
                    idx = i;
            if (idx < 0)
            begin
                a.status = klc_pkg::STATUS_FULL;
                n_full++;
            end
            else
            begin
                line_valid[idx] = 1'b1;
                line_key[idx]   = req_key;
                line_off[idx]   = req_off;
                line_len[idx]   = req_len;
                use_cnt[idx]    = 4'd1;
                own_cnt[idx]    = '0;
                a.slot          = idx[klc_pkg::SLOT_W-1:0];
            end
        end
        else
        begin
            // Lowest valid entry holding the key.
            for (i = N_ENTRIES - 1; i >= 0; i--)
                if (line_valid[i] && line_key[i] == req_key)
                    idx = i;
            if (idx < 0)
            begin
                a.status = klc_pkg::STATUS_NOT_FOUND;
                n_not_found++;
            end
            else
            begin
                a.slot = idx[klc_pkg::SLOT_W-1:0];
                if (req_kind == klc_pkg::KIND_LOOKUP)
                begin
                    a.offset = line_off[idx];
                    a.length = line_len[idx];
                    n_hits++;
                    if (use_cnt[idx] == klc_pkg::COUNT_MAX)
                        n_clamps++;
                    else
                        use_cnt[idx] = use_cnt[idx] + 4'd1;
                end
                else if (req_kind == klc_pkg::KIND_ADD_OWNER)
                begin
                    if (own_cnt[idx] == klc_pkg::COUNT_MAX)
                        n_clamps++;
                    else
                        own_cnt[idx] = own_cnt[idx] + 4'd1;
                end
                else
                begin
                    if (own_cnt[idx] == '0)
                        n_clamps++;
                    else
                        own_cnt[idx] = own_cnt[idx] - 4'd1;
                end
            end
        end
        return a;
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [klc_pkg::KEY_W-1:0] got,
                                   input logic [klc_pkg::KEY_W-1:0] want);
        n_errors++;
        $display("result beat %0d: %s is %0h, expected %0h", n_beats, what, got, want);
    endtask

    task automatic queue_request(input logic [klc_pkg::KIND_W-1:0] req_kind,
                                 input logic [klc_pkg::KEY_W-1:0]  req_key,
                                 input logic [klc_pkg::WORD_W-1:0] req_off,
                                 input logic [klc_pkg::WORD_W-1:0] req_len,
                                 input bit                         req_drain);
        request_t r;
        r.kind   = req_kind;
        r.key    = req_key;
        r.offset = req_off;
        r.length = req_len;
        r.drain  = req_drain;
        pending.push_back(r);
        n_items++;
    endtask

    function automatic logic [klc_pkg::KEY_W-1:0] pick_key();
        logic [klc_pkg::KEY_W-1:0] k;
        if ($urandom_range(0, 9) == 0)
            k = {$urandom(), $urandom()};
        else
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return k;
    endfunction

    // Driver: presents the next request at the falling edge once the last one was taken.
    always @(negedge clk)
    begin
        if (rst_n && (!start || took_beat))
        begin
            if (pending.size() == 0)
                start <= 1'b0;
            else if (pending[0].drain && (awaiting.size() != 0 || busy))
                start <= 1'b0;
            else if (!(n_sent >= 250 && n_sent < 400) && $urandom_range(0, 99) < 23)
                start <= 1'b0;
            else
            begin
                next_req    = pending.pop_front();
                kind        <= next_req.kind;
                key         <= next_req.key;
                line_offset <= next_req.offset;
                line_length <= next_req.length;
                start       <= 1'b1;
                n_sent++;
            end
        end
    end

    // Monitor: checks each result beat, then predicts for a request taken at this edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            took_beat <= 1'b0;
        end
        else
        begin
            if (done)
            begin
                n_beats++;
                if (awaiting.size() == 0)
                begin
                    report_mismatch("result beat with nothing outstanding, status",
                                    klc_pkg::KEY_W'(status), '0);
                end
                else
                begin
                    got_beat = awaiting.pop_front();
                    if (status !== got_beat.status)
                        report_mismatch("status", klc_pkg::KEY_W'(status),
                                        klc_pkg::KEY_W'(got_beat.status));
                    if (slot !== got_beat.slot)
                        report_mismatch("slot", klc_pkg::KEY_W'(slot),
                                        klc_pkg::KEY_W'(got_beat.slot));
                    if (found_offset !== got_beat.offset)
                        report_mismatch("found_offset", klc_pkg::KEY_W'(found_offset),
                                        klc_pkg::KEY_W'(got_beat.offset));
                    if (found_length !== got_beat.length)
                        report_mismatch("found_length", klc_pkg::KEY_W'(found_length),
                                        klc_pkg::KEY_W'(got_beat.length));
                end
            end
            if (start && !busy)
            begin
                awaiting.push_back(serve_request(kind, key, line_offset, line_length));
                n_accepted++;
            end
            took_beat <= start && !busy;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycles, awaiting.size());
            $display("keyed_line_cache_with_owner_counts: mismatch");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int seq;
        int pick;
        int j;
        int r;
        logic [klc_pkg::KEY_W-1:0] k;

        start       = 1'b0;
        kind        = klc_pkg::KIND_LOOKUP;
        key         = '0;
        line_offset = '0;
        line_length = '0;
        for (j = 0; j < N_ENTRIES; j++)
        begin
            line_valid[j] = 1'b0;
            line_key[j]   = '0;
            line_off[j]   = '0;
            line_len[j]   = '0;
            use_cnt[j]    = '0;
            own_cnt[j]    = '0;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (j = 2; j < POOL_SIZE; j++)
            key_pool[j] = {$urandom(), $urandom()};

        // Directed: empty table, extreme fields, owner clamp at zero, duplicates.
        queue_request(klc_pkg::KIND_LOOKUP,    '0, '0, '0, 1'b0);
        queue_request(klc_pkg::KIND_ADD_OWNER, '0, '0, '0, 1'b0);
        queue_request(klc_pkg::KIND_REM_OWNER, '1, '1, '1, 1'b0);
        queue_request(klc_pkg::KIND_INSERT,    '0, '0, '0, 1'b0);
        queue_request(klc_pkg::KIND_ADD_OWNER, '0, '1, '1, 1'b0);
        queue_request(klc_pkg::KIND_INSERT,    '1, '1, '1, 1'b0);
        queue_request(klc_pkg::KIND_LOOKUP,    '1, '0, '0, 1'b0);
        queue_request(klc_pkg::KIND_LOOKUP,    '0, '1, '1, 1'b0);
        queue_request(klc_pkg::KIND_REM_OWNER, '0, '0, '0, 1'b0);
        queue_request(klc_pkg::KIND_REM_OWNER, '0, '0, '0, 1'b0);
        queue_request(klc_pkg::KIND_INSERT,    '1, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b0);
        queue_request(klc_pkg::KIND_LOOKUP,    '0, '0, '0, 1'b0);
        queue_request(klc_pkg::KIND_LOOKUP,    '1, '0, '0, 1'b0);
        queue_request(klc_pkg::KIND_ADD_OWNER, '1, '0, '0, 1'b0);
        queue_request(klc_pkg::KIND_ADD_OWNER, '1, '0, '0, 1'b0);
        queue_request(klc_pkg::KIND_INSERT,    key_pool[2], $urandom(), $urandom(), 1'b0);
        queue_request(klc_pkg::KIND_LOOKUP,    key_pool[2], '0, '0, 1'b0);

        // Random part: the first three sequences fill the table, hammer the counts into
        // saturation and release owners; after that the mix is chosen at random.
        seq = 0;
        while (n_items < ITEM_TARGET)
        begin
            if (seq == 0)
                pick = 0;
            else if (seq == 1)
                pick = 3;
            else if (seq == 2)
                pick = 2;
            else
                pick = $urandom_range(0, 11);
            seq++;
            case (pick)
                0, 1:
                begin
                    // Insert one owned line per entry from the key pool, then try to insert past full.
                    for (j = 0; j < N_ENTRIES; j++)
                    begin
                        queue_request(klc_pkg::KIND_INSERT, key_pool[j], $urandom(),
                                      $urandom(), j == 0);
                        queue_request(klc_pkg::KIND_ADD_OWNER, key_pool[j], $urandom(),
                                      $urandom(), 1'b0);
                    end
                    queue_request(klc_pkg::KIND_INSERT, {$urandom(), $urandom()}, $urandom(),
                                  $urandom(), 1'b0);
                    queue_request(klc_pkg::KIND_INSERT, key_pool[POOL_SIZE - 1], $urandom(),
                                  $urandom(), 1'b0);
                end
                2:
                begin
                    // Release owners so that inserts find room again.
                    for (j = 0; j < POOL_SIZE; j++)
                        for (r = $urandom_range(1, 3); r > 0; r--)
                            queue_request(klc_pkg::KIND_REM_OWNER, key_pool[j], $urandom(),
                                          $urandom(), j == 0 && r == 1);
                end
                3:
                begin
                    // Drive one line's use count to its upper limit and its owner count to both limits.
                    k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                    queue_request(klc_pkg::KIND_INSERT, k, $urandom(), $urandom(), 1'b0);
                    for (j = 0; j < 17; j++)
                        queue_request(klc_pkg::KIND_LOOKUP, k, $urandom(), $urandom(), 1'b0);
                    for (j = 0; j < 17; j++)
                        queue_request(klc_pkg::KIND_ADD_OWNER, k, $urandom(), $urandom(),
                                      1'b0);
                    for (j = 0; j < 17; j++)
                        queue_request(klc_pkg::KIND_REM_OWNER, k, $urandom(), $urandom(),
                                      1'b0);
                end
                4:
                begin
                    // Noise: unrelated keys and any kind.
                    for (j = 0; j < 6; j++)
                        queue_request(klc_pkg::KIND_W'($urandom_range(0, 3)),
                                      {$urandom(), $urandom()}, $urandom(), $urandom(), 1'b0);
                end
                5:
                begin
                    // Duplicate insert of one key, then act on the lowest copy.
                    k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                    queue_request(klc_pkg::KIND_INSERT, k, $urandom(), $urandom(), 1'b0);
                    queue_request(klc_pkg::KIND_INSERT, k, $urandom(), $urandom(), 1'b0);
                    queue_request(klc_pkg::KIND_LOOKUP, k, $urandom(), $urandom(), 1'b0);
                    queue_request(klc_pkg::KIND_ADD_OWNER, k, $urandom(), $urandom(), 1'b0);
                    queue_request(klc_pkg::KIND_LOOKUP, k, $urandom(), $urandom(), 1'b0);
                    queue_request(klc_pkg::KIND_REM_OWNER, k, $urandom(), $urandom(), 1'b0);
                end
                default:
                begin
                    // Mixed traffic, mostly on the key pool.
                    for (j = 0; j < 8; j++)
                        queue_request(klc_pkg::KIND_W'($urandom_range(0, 3)), pick_key(),
                                      $urandom(), $urandom(), 1'b0);
                end
            endcase
        end

        while (n_accepted < n_items)
            @(posedge clk);
        while (awaiting.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d requests, %0d result beats: %0d lookup hits, %0d key misses,",
                 n_accepted, n_beats, n_hits, n_not_found);
        $display("%0d inserts refused on a full table, %0d counts held at a limit",
                 n_full, n_clamps);
        if (n_errors == 0)
            $display("keyed_line_cache_with_owner_counts: match");
        else
            $display("keyed_line_cache_with_owner_counts: mismatch");
        $finish;
    end

endmodule
